/* sv/bcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_pkg: shared types, constants and character functions
// Holds the base-34 alphabet mapping, the queue entry and the result beat
// layout that the front, the queue, the back and the top level share.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int unsigned DIGIT_BASE = 34;
  localparam int unsigned CODE_LEN   = 25;
  localparam int unsigned SUM_LEN    = 24;
  localparam int unsigned COUNT_MAX  = 31;
  localparam int unsigned PORT_BITS  = 16;
  localparam int unsigned ROOM_BITS  = 48;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CHAR_W     = 7;

  // Queue between front and back.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // ASCII landmarks.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // First digit value of each contiguous letter run of the alphabet.
  localparam logic [7:0] DIG_A = 8'd10;
  localparam logic [7:0] DIG_J = 8'd18;
  localparam logic [7:0] DIG_P = 8'd23;

  typedef enum logic {
    REQ_CHAR = 1'b0,
    REQ_END  = 1'b1
  } req_t;

  typedef enum logic {
    KIND_ECHO    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic                 ok;
    logic [DIGIT_W-1:0]   digit;
  } digit_dec_t;

  typedef struct packed {
    logic                 is_end;
    logic [DIGIT_W-1:0]   digit;
  } q_entry_t;

  typedef struct packed {
    kind_t                kind;
    logic [COUNT_W-1:0]   position;
    logic [DIGIT_W-1:0]   digit_value;
    logic [CHAR_W-1:0]    norm_char;
    logic                 valid_res;
    logic [PORT_BITS-1:0] port_out;
    logic [ROOM_BITS-1:0] room_out;
  } res_t;

  // Maps a raw byte onto a base-34 digit; ok is low for a skipped byte.
  function automatic digit_dec_t char_to_digit(input logic [7:0] b);
    logic [7:0] u;
    digit_dec_t r;
    r.ok    = 1'b0;
    r.digit = '0;
    u       = b;
    if (u >= CH_LOW_A && u <= CH_LOW_Z) begin
      u = u - CASE_GAP;
    end
    if (u == CH_I) begin
      u = CH_0 + 8'd1;
    end
    if (u == CH_O) begin
      u = CH_0;
    end
    if (u >= CH_0 && u <= CH_9) begin
      r.ok    = 1'b1;
      r.digit = DIGIT_W'(u - CH_0);
    end else if (u >= CH_A && u <= CH_H) begin
      r.ok    = 1'b1;
      r.digit = DIGIT_W'(u - CH_A + DIG_A);
    end else if (u >= CH_J && u <= CH_N) begin
      r.ok    = 1'b1;
      r.digit = DIGIT_W'(u - CH_J + DIG_J);
    end else if (u >= CH_P && u <= CH_Z) begin
      r.ok    = 1'b1;
      r.digit = DIGIT_W'(u - CH_P + DIG_P);
    end
    return r;
  endfunction

  // Maps a digit value back onto its alphabet character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] dw;
    logic [7:0] c;
    dw = {2'b00, d};
    if (dw < DIG_A) begin
      c = CH_0 + dw;
    end else if (dw < DIG_J) begin
      c = CH_A + (dw - DIG_A);
    end else if (dw < DIG_P) begin
      c = CH_J + (dw - DIG_J);
    end else begin
      c = CH_P + (dw - DIG_P);
    end
    return c[CHAR_W-1:0];
  endfunction

endpackage

/* sv/base34_code_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base34_code_parser: streaming base-34 code parser
// Checks a 25-digit base-34 code with a mod-34 checksum and decodes its
// little-endian value into a 16-bit port and a 48-bit room number.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per code character (in_req_type = 0,
//   byte on in_char_code) and a final beat with in_req_type = 1 as the end
//   marker. Bytes outside 0-9, A-Z and a-z are accepted and dropped with no
//   result. Each kept character gives one echo beat on the output channel
//   with its position, digit value and normalized character; the end marker
//   gives one verdict beat and returns the parser to its reset state.
//   A result beat passes through the queue and the output register.
//   Throughput: one beat per cycle on both sides while out_ready is high.
//   The classifier and the accumulator are parted by a two-entry queue and
//   the result sits in an output register, so a new input beat is accepted
//   while a finished result still waits. The accumulator's digit-times-power
//   product is registered and added in the next cycle; the verdict adds any
//   pending product.
//   When the receiver stalls, the output register holds its beat, the queue
//   fills, and in_ready drops once both entries are taken.
//   Reset (rst_n low, synchronous) empties the queue and the output register
//   and clears count, checksum and value, with the place power set to one.
// ----------------------------------------------------------------------------
module base34_code_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_req_type,
  input  logic [7:0]   in_char_code,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_kind,
  output logic [4:0]   out_position,
  output logic [5:0]   out_digit_value,
  output logic [6:0]   out_norm_char,
  output logic         out_valid_res,
  output logic [15:0]  out_port_out,
  output logic [47:0]  out_room_out
);

  // Front to queue.
  logic              q_ready;
  logic              q_push;
  bcp_pkg::q_entry_t q_in;

  // Queue to back.
  logic              q_valid;
  logic              q_pop;
  bcp_pkg::q_entry_t q_head;

  bcp_pkg::res_t     res;

  bcp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  bcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  bcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Unpack the registered result beat onto the output ports.
  assign out_kind        = res.kind;
  assign out_position    = res.position;
  assign out_digit_value = res.digit_value;
  assign out_norm_char   = res.norm_char;
  assign out_valid_res   = res.valid_res;
  assign out_port_out    = res.port_out;
  assign out_room_out    = res.room_out;

endmodule

/* sv/bcp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_front: input classifier
// Decodes each input beat into a digit or an end marker and drops bytes
// outside the alphabet before they reach the queue.
// ----------------------------------------------------------------------------
module bcp_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [7:0]          in_char_code,
  input  logic                q_ready,
  output logic                q_push,
  output bcp_pkg::q_entry_t   q_data
);

  bcp_pkg::digit_dec_t dec;
  logic                is_end;

  assign dec      = bcp_pkg::char_to_digit(in_char_code);
  assign is_end   = (in_req_type == bcp_pkg::REQ_END);
  assign in_ready = q_ready;

  // Skipped bytes are accepted but never enter the queue.
  assign q_push        = in_valid && q_ready && (is_end || dec.ok);
  assign q_data.is_end = is_end;
  assign q_data.digit  = is_end ? '0 : dec.digit;

endmodule

/* sv/bcp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_queue: classified item queue
// A small register FIFO that decouples the classifier from the back end,
// with simultaneous push and pop when full.
// ----------------------------------------------------------------------------
module bcp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bcp_pkg::q_entry_t push_data,
  output logic              ready,
  output logic              valid,
  output bcp_pkg::q_entry_t head,
  input  logic              pop
);

  localparam logic [bcp_pkg::QPTR_W-1:0] PTR_LAST = bcp_pkg::QPTR_W'(bcp_pkg::QDEPTH - 1);
  localparam logic [bcp_pkg::QCNT_W-1:0] CNT_FULL = bcp_pkg::QCNT_W'(bcp_pkg::QDEPTH);

  bcp_pkg::q_entry_t             mem_r [bcp_pkg::QDEPTH];
  logic [bcp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bcp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bcp_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign valid   = (cnt_r != '0);
  assign ready   = (cnt_r != CNT_FULL) || pop;
  assign head    = mem_r[rd_ptr_r];
  assign do_pop  = pop && valid;
  assign do_push = push && ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue occupancy above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with mismatched pointers");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_FULL && push && !pop) |=> (cnt_r == CNT_FULL))
    else $error("push into full queue changed occupancy");

endmodule

/* sv/bcp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_back: digit accumulator and verdict unit
// Pops classified items, keeps the count, checksum and little-endian
// value, and loads each result beat into the output register.
// ----------------------------------------------------------------------------
module bcp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  bcp_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output bcp_pkg::res_t     out_res
);

  localparam int unsigned VW = bcp_pkg::VALUE_BITS;
  localparam int unsigned DW = bcp_pkg::DIGIT_W;
  localparam int unsigned CW = bcp_pkg::COUNT_W;

  localparam logic [CW-1:0]  CNT_CODE = CW'(bcp_pkg::CODE_LEN);
  localparam logic [CW-1:0]  CNT_SUM  = CW'(bcp_pkg::SUM_LEN);
  localparam logic [CW-1:0]  CNT_MAX  = CW'(bcp_pkg::COUNT_MAX);
  localparam logic [DW:0]    BASE_W   = (DW + 1)'(bcp_pkg::DIGIT_BASE);

  logic [CW-1:0]  count_r, count_nxt;
  logic [DW-1:0]  sum_r, sum_nxt;
  logic           match_r, match_nxt;
  logic [VW-1:0]  value_acc_r, value_acc_nxt;
  logic [VW-1:0]  prod_r, prod_nxt;
  logic [VW-1:0]  power_r, power_nxt;
  logic           out_valid_r, out_valid_nxt;
  bcp_pkg::res_t  res_r, res_nxt;

  logic [DW:0]    sum_add;
  logic [VW-1:0]  total;
  logic           verdict_ok;
  logic           pop_end;
  logic [DW-1:0]  d;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign pop_end   = q_pop && q_head.is_end;
  assign d         = q_head.digit;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // The product of the previous digit is folded in during the following cycle.
  assign total      = value_acc_r + prod_r;
  assign verdict_ok = (count_r == CNT_CODE) && match_r;
  assign sum_add    = {1'b0, sum_r} + {1'b0, d};

  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    match_nxt     = match_r;
    value_acc_nxt = total;
    prod_nxt      = '0;
    power_nxt     = power_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (q_head.is_end) begin
        res_nxt.kind      = bcp_pkg::KIND_VERDICT;
        res_nxt.valid_res = verdict_ok;
        if (verdict_ok) begin
          res_nxt.port_out = total[bcp_pkg::PORT_BITS-1:0];
          res_nxt.room_out = total[VW-1:bcp_pkg::PORT_BITS];
        end
        count_nxt     = '0;
        sum_nxt       = '0;
        match_nxt     = 1'b0;
        value_acc_nxt = '0;
        power_nxt     = VW'(1);
      end else begin
        res_nxt.kind        = bcp_pkg::KIND_ECHO;
        res_nxt.position    = count_r;
        res_nxt.digit_value = d;
        res_nxt.norm_char   = bcp_pkg::digit_to_char(d);
        if (count_r < CNT_SUM) begin
          sum_nxt = (sum_add >= BASE_W) ? DW'(sum_add - BASE_W) : sum_add[DW-1:0];
        end
        if (count_r == CNT_SUM) begin
          match_nxt = (sum_r == d);
        end
        prod_nxt  = power_r * {{(VW-DW){1'b0}}, d};
        // Times 34 as 32 + 2.
        power_nxt = (power_r << 5) + (power_r << 1);
        if (count_r != CNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      match_r     <= 1'b0;
      value_acc_r <= '0;
      prod_r      <= '0;
      power_r     <= VW'(1);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      match_r     <= match_nxt;
      value_acc_r <= value_acc_nxt;
      prod_r      <= prod_nxt;
      power_r     <= power_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r < BASE_W[DW-1:0])
    else $error("checksum out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop_end |=> (count_r == '0) && (prod_r == '0) && (value_acc_r == '0) && !match_r)
    else $error("state not cleared after end marker");

  a_prod_source: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_r != '0) |-> $past(q_pop && !q_head.is_end))
    else $error("pending product without a digit");

  a_verdict_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.valid_res) |-> (res_r.kind == bcp_pkg::KIND_VERDICT))
    else $error("valid flag on a digit echo");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped item did not reach the output register");

endmodule
